### sv/ece_pkg.sv
// ============================================================================
// ece_pkg - shared types and constants of the easing curve evaluator
// Fixed-point formats, curve codes, register map and pipeline control word.
// ============================================================================
package ece_pkg;

    // Fraction bits of the fixed-point formats
    localparam int FRAC_BITS = 15;

    // Progress t: unsigned Q1.F; eased value: signed Q2.F
    localparam int T_W   = FRAC_BITS + 1;
    localparam int OUT_W = FRAC_BITS + 2;

    // Datapath operands hold up to about +/-16.0 in Q.F
    localparam int OP_W   = FRAC_BITS + 5;
    localparam int PROD_W = 2 * OP_W;
    localparam int POST_W = OP_W + 2;

    // Configuration port
    localparam int CFG_W     = 4;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_CURVE_SELECT = '0;

    // Fixed-point constants (overshoot constants rounded to nearest)
    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint HALF_L = longint'(1) << (FRAC_BITS - 1);
    localparam longint C2_L   =
        ((longint'(25949095) << FRAC_BITS) + longint'(5000000)) / 10000000;
    localparam longint C2P1_L =
        ((longint'(35949095) << FRAC_BITS) + longint'(5000000)) / 10000000;

    // Curve codes; codes past the last one act as linear
    typedef enum logic [CFG_W-1:0] {
        CRV_LINEAR       = 4'd0,
        CRV_SMOOTHSTEP   = 4'd1,
        CRV_SMOOTHERSTEP = 4'd2,
        CRV_QUAD_IN      = 4'd3,
        CRV_QUAD_OUT     = 4'd4,
        CRV_QUAD_INOUT   = 4'd5,
        CRV_CUBIC_IN     = 4'd6,
        CRV_CUBIC_OUT    = 4'd7,
        CRV_CUBIC_INOUT  = 4'd8,
        CRV_INOUT_BACK   = 4'd9
    } t_curve;

    // Control word that travels with each item down the pipeline
    typedef struct packed {
        logic [CFG_W-1:0] sel;   // curve code
        logic             lo;    // t below one half
    } t_item_ctl;

endpackage

### sv/ece_apb_regs.sv
// ============================================================================
// ece_apb_regs - configuration register file
// APB-style slave holding the curve select register; always ready.
// ============================================================================
module ece_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ece_pkg::PADDR_W-1:0]   paddr,
    input  logic [ece_pkg::DATA_W-1:0]    pwdata,
    output logic [ece_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [ece_pkg::CFG_W-1:0]     o_curve_sel
);
    import ece_pkg::*;

    logic [CFG_W-1:0]     r_curve_select;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Decode the word index from the byte address
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_CURVE_SELECT);

    // Hold the curve select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_select <= CRV_LINEAR;
        end else if (wr_en) begin
            r_curve_select <= pwdata[CFG_W-1:0];
        end
    end

    // Read back; unmapped words read as zero
    assign prdata      = (reg_idx == REG_CURVE_SELECT) ? DATA_W'(r_curve_select) : '0;
    assign pready      = 1'b1;
    assign o_curve_sel = r_curve_select;

endmodule

### sv/ece_datapath.sv
// ============================================================================
// ece_datapath - multiply pipeline of the easing curve evaluator
// Three multiply stages and a post-add/clamp output stage, each with its
// own valid bit and ready term so bubbles close up under backpressure.
// ============================================================================
module ece_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [ece_pkg::T_W-1:0]          i_t,
    input  ece_pkg::t_item_ctl               i_ctl,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [ece_pkg::OUT_W-1:0] o_value
);
    import ece_pkg::*;

    localparam logic signed [OP_W-1:0] ONE_Q     = OP_W'(ONE_L);
    localparam logic signed [OP_W-1:0] TWO_Q     = OP_W'(2 * ONE_L);
    localparam logic signed [OP_W-1:0] THREE_Q   = OP_W'(3 * ONE_L);
    localparam logic signed [OP_W-1:0] FOUR_Q    = OP_W'(4 * ONE_L);
    localparam logic signed [OP_W-1:0] TEN_Q     = OP_W'(10 * ONE_L);
    localparam logic signed [OP_W-1:0] FIFTEEN_Q = OP_W'(15 * ONE_L);
    localparam logic signed [OP_W-1:0] C2_Q      = OP_W'(C2_L);
    localparam logic signed [OP_W-1:0] C2P1_Q    = OP_W'(C2P1_L);

    localparam logic signed [POST_W-1:0] ONE_W   = POST_W'(ONE_L);
    localparam logic signed [POST_W-1:0] TWO_W   = POST_W'(2 * ONE_L);
    localparam logic signed [POST_W-1:0] MAX_W   = POST_W'(2 * ONE_L - 1);
    localparam logic signed [POST_W-1:0] MIN_W   = -POST_W'(2 * ONE_L);

    // Q.F product, floor shift
    function automatic logic signed [OP_W-1:0] qmul(
        input logic signed [OP_W-1:0] a,
        input logic signed [OP_W-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return p[FRAC_BITS +: OP_W];
    endfunction

    // Stage registers
    logic                   r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic signed [OP_W-1:0] r_s1_a, r_s1_b, r_s1_cy;
    logic signed [OP_W-1:0] r_s2_c, r_s2_d;
    logic signed [OP_W-1:0] r_s3_e;
    t_item_ctl              r_s1_ctl, r_s2_ctl, r_s3_ctl;
    logic signed [OUT_W-1:0] r_out_value;

    logic rdy1, rdy2, rdy3, rdy_out;

    // Ready terms: a stage moves when empty or when its successor moves
    assign rdy_out = !r_out_valid || i_ready;
    assign rdy3    = !r_s3_valid  || rdy_out;
    assign rdy2    = !r_s2_valid  || rdy3;
    assign rdy1    = !r_s1_valid  || rdy2;
    assign o_ready = rdy1;

    // ---------------- stage 1: operand select and two products ----------------
    logic signed [OP_W-1:0] tt, f, g_hi, g_lo, g_bk;
    logic signed [OP_W-1:0] ax, ay, bx, by, n_s1_cy;

    assign tt   = signed'(OP_W'(i_t));
    assign f    = tt - ONE_Q;
    assign g_lo = tt <<< 1;
    assign g_hi = (tt <<< 1) - TWO_Q;
    assign g_bk = i_ctl.lo ? g_lo : g_hi;

    // Pick multiplier operands for the chosen curve
    always_comb begin
        ax      = tt;
        ay      = ONE_Q;
        bx      = tt;
        by      = ONE_Q;
        n_s1_cy = ONE_Q;
        unique case (i_ctl.sel)
            CRV_SMOOTHSTEP: begin
                ay      = tt;
                n_s1_cy = THREE_Q - (tt <<< 1);
            end
            CRV_SMOOTHERSTEP: begin
                ay      = tt;
                by      = (tt <<< 2) + (tt <<< 1) - FIFTEEN_Q;
                n_s1_cy = tt;
            end
            CRV_QUAD_IN: begin
                ay = tt;
            end
            CRV_QUAD_OUT: begin
                by = TWO_Q - tt;
            end
            CRV_QUAD_INOUT: begin
                ay = tt;
                by = FOUR_Q - (tt <<< 1);
            end
            CRV_CUBIC_IN: begin
                ay      = tt;
                n_s1_cy = tt;
            end
            CRV_CUBIC_OUT: begin
                bx      = f;
                by      = f;
                n_s1_cy = f;
            end
            CRV_CUBIC_INOUT: begin
                ay      = tt;
                bx      = f;
                by      = g_hi;
                n_s1_cy = i_ctl.lo ? tt : g_hi;
            end
            CRV_INOUT_BACK: begin
                ax = g_bk;
                ay = g_bk;
                bx = C2P1_Q;
                by = g_bk;
            end
            default: begin
                ax = tt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rdy1) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_a   <= qmul(ax, ay);
            r_s1_b   <= qmul(bx, by);
            r_s1_cy  <= n_s1_cy;
            r_s1_ctl <= i_ctl;
        end
    end

    // ---------------- stage 2: second product and addend ----------------
    logic signed [OP_W-1:0] cx, n_s2_d;

    // Choose which first-stage product feeds on, and form the second factor
    always_comb begin
        cx     = r_s1_a;
        n_s2_d = ONE_Q;
        unique case (r_s1_ctl.sel)
            CRV_SMOOTHERSTEP: begin
                n_s2_d = r_s1_b + TEN_Q;
            end
            CRV_QUAD_OUT, CRV_CUBIC_OUT: begin
                cx = r_s1_b;
            end
            CRV_QUAD_INOUT, CRV_CUBIC_INOUT: begin
                cx = r_s1_ctl.lo ? r_s1_a : r_s1_b;
            end
            CRV_INOUT_BACK: begin
                n_s2_d = r_s1_ctl.lo ? (r_s1_b - C2_Q) : (r_s1_b + C2_Q);
            end
            default: begin
                cx = r_s1_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_s1_valid) begin
            r_s2_c   <= qmul(cx, r_s1_cy);
            r_s2_d   <= n_s2_d;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    // ---------------- stage 3: final product ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (rdy3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_valid) begin
            r_s3_e   <= qmul(r_s2_c, r_s2_d);
            r_s3_ctl <= r_s2_ctl;
        end
    end

    // ---------------- stage 4: post add, halve and clamp ----------------
    logic signed [POST_W-1:0] e_w, post, n_clamped;

    assign e_w = POST_W'(r_s3_e);

    always_comb begin
        unique case (r_s3_ctl.sel)
            CRV_QUAD_INOUT:  post = r_s3_ctl.lo ? (e_w <<< 1) : (e_w - ONE_W);
            CRV_CUBIC_OUT:   post = e_w + ONE_W;
            CRV_CUBIC_INOUT: post = r_s3_ctl.lo ? (e_w <<< 2) : (e_w + ONE_W);
            CRV_INOUT_BACK:  post = r_s3_ctl.lo ? (e_w >>> 1) : ((e_w + TWO_W) >>> 1);
            default:         post = e_w;
        endcase
    end

    // Saturate to the signed Q2.F range
    always_comb begin
        priority if (post > MAX_W) begin
            n_clamped = MAX_W;
        end else if (post < MIN_W) begin
            n_clamped = MIN_W;
        end else begin
            n_clamped = post;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out && r_s3_valid) begin
            r_out_value <= n_clamped[OUT_W-1:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

endmodule

### sv/easing_curve_evaluator_core.sv
// ============================================================================
// easing_curve_evaluator_core - easing curve evaluator, top level
// Maps a progress value to an eased value for the selected easing curve.
// ============================================================================
// Usage:
//   Input channel (i_progress_valid / o_progress_ready / i_progress) takes
//   one word per cycle while o_progress_ready is high: progress t in
//   unsigned Q1.15, values above 1.0 saturate to 1.0. Output channel
//   (o_eased_value_valid / i_eased_value_ready / o_eased_value) delivers
//   one word per input word, in order: the eased value in signed Q2.15.
//   The curve comes from the curve select register at byte address 0 of
//   the APB port; change it only while no words are in flight.
//   Each word passes through an input register, three multiply stages
//   and an output register. Throughput is one word per cycle while the
//   receiver does not stall, as the multipliers in each stage are
//   combinational.
//   Each stage has its own valid bit; while the receiver stalls, empty
//   stages keep filling and the input stalls only once all are full.
//   Reset empties the pipeline and sets the curve select to linear.
// ============================================================================
module easing_curve_evaluator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ece_pkg::PADDR_W-1:0]      paddr,
    input  logic [ece_pkg::DATA_W-1:0]       pwdata,
    output logic [ece_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             i_progress_valid,
    output logic                             o_progress_ready,
    input  logic [ece_pkg::T_W-1:0]          i_progress,
    output logic                             o_eased_value_valid,
    input  logic                             i_eased_value_ready,
    output logic signed [ece_pkg::OUT_W-1:0] o_eased_value
);
    import ece_pkg::*;

    logic [CFG_W-1:0] curve_sel;
    logic             r_s0_valid;
    logic [T_W-1:0]   r_s0_t;
    t_item_ctl        r_s0_ctl;
    logic [T_W-1:0]   n_s0_t;
    t_item_ctl        n_s0_ctl;
    logic             dp_ready;
    logic             rdy0;

    ece_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_curve_sel (curve_sel)
    );

    // Saturate progress to 1.0 and tag the word with its curve and half
    assign n_s0_t       = (i_progress > T_W'(ONE_L)) ? T_W'(ONE_L) : i_progress;
    assign n_s0_ctl.sel = curve_sel;
    assign n_s0_ctl.lo  = (n_s0_t < T_W'(HALF_L));

    assign rdy0             = !r_s0_valid || dp_ready;
    assign o_progress_ready = rdy0;

    // Input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (rdy0) begin
            r_s0_valid <= i_progress_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_progress_valid) begin
            r_s0_t   <= n_s0_t;
            r_s0_ctl <= n_s0_ctl;
        end
    end

    ece_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .o_ready (dp_ready),
        .i_t     (r_s0_t),
        .i_ctl   (r_s0_ctl),
        .o_valid (o_eased_value_valid),
        .i_ready (i_eased_value_ready),
        .o_value (o_eased_value)
    );

endmodule
